>>> rtl/jaf_pkg.sv
package jaf_pkg;

    // Window geometry
    localparam int WINDOW = 8;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Field widths
    localparam int POS_W     = 16;
    localparam int ANG_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = ANG_W + CNT_W;

    // 2pi in Q3.16
    localparam int TAU_W = 19;
    localparam logic [TAU_W-1:0] TAU_Q16 = 19'd411775;

    // Shared divider geometry
    localparam int PROD_W = POS_W + TAU_W;
    localparam int DVD_W  = PROD_W + 1;
    localparam int DVS_W  = CFG_W + 4;
    localparam int Q_W    = 16;

    // Wrap and scale
    localparam int V_W   = 18;
    localparam int SCL_W = V_W + CFG_W;
    localparam logic signed [V_W-1:0] PI_Q12  = 18'sd12868;
    localparam logic signed [V_W-1:0] TAU_Q12 = 18'sd25736;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUNTS = 2'd0,
        REG_OFFSET = 2'd1,
        REG_RATIO  = 2'd2
    } cfg_reg_t;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_MUL   = 11'b000_0000_0010,
        ST_CDIV  = 11'b000_0000_0100,
        ST_CWAIT = 11'b000_0000_1000,
        ST_STORE = 11'b000_0001_0000,
        ST_SUM   = 11'b000_0010_0000,
        ST_ADIV  = 11'b000_0100_0000,
        ST_AWAIT = 11'b000_1000_0000,
        ST_WRAP  = 11'b001_0000_0000,
        ST_SCALE = 11'b010_0000_0000,
        ST_OUT   = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic div_start;
        logic div_avg;
        logic store;
        logic sum;
        logic wrap;
        logic scale;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sum_done;
    } stat_t;

endpackage

>>> rtl/jaf_ram.sv
module jaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/jaf_div.sv
module jaf_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [jaf_pkg::DVD_W-1:0] dividend,
    input  logic [jaf_pkg::DVS_W-1:0] divisor,
    output logic [jaf_pkg::Q_W-1:0]   quotient,
    output logic                      ovf,
    output logic                      done
);
    import jaf_pkg::*;

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [DVD_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  dsr_reg, dsr_next;
    logic [Q_W-1:0]    q_reg, q_next;
    logic              ovf_reg, ovf_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsr_next  = DVD_W'({divisor, {(Q_W-1){1'b0}}});
            q_next    = '0;
            ovf_next  = ({1'b0, dividend} >= (DVD_W+1)'({divisor, {Q_W{1'b0}}}));
            step_next = STEP_W'(Q_W);
        end else if (step_reg != '0) begin
            if (rem_reg >= dsr_reg) begin
                rem_next = rem_reg - dsr_reg;
                q_next   = {q_reg[Q_W-2:0], 1'b1};
            end else begin
                q_next   = {q_reg[Q_W-2:0], 1'b0};
            end
            dsr_next  = dsr_reg >> 1;
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign quotient = q_reg;
    assign ovf      = ovf_reg;
    assign done     = done_reg;

endmodule

>>> rtl/jaf_datapath.sv
module jaf_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [jaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jaf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [jaf_pkg::POS_W-1:0]     s_raw_position,
    input  jaf_pkg::cmd_t                 cmd,
    output jaf_pkg::stat_t                stat,
    output logic signed [jaf_pkg::ANG_W-1:0] m_joint_angle
);
    import jaf_pkg::*;

    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [IDX_W-1:0] WIN_LAST = IDX_W'(WINDOW - 1);

    // Configuration registers
    logic [CFG_W-1:0]        cpt_reg;
    logic signed [CFG_W-1:0] offset_reg;
    logic signed [CFG_W-1:0] ratio_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpt_reg    <= CFG_W'(4096);
            offset_reg <= '0;
            ratio_reg  <= CFG_W'(4096);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_COUNTS: cpt_reg    <= cfg_wr_data;
                REG_OFFSET: offset_reg <= cfg_wr_data;
                REG_RATIO:  ratio_reg  <= cfg_wr_data;
                default:    ;
            endcase
        end
    end

    // Payload and control registers
    logic [POS_W-1:0]        pos_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [IDX_W-1:0]        wr_ptr_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    rd_vld_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [V_W-1:0]   v_reg;
    logic signed [SCL_W-1:0] scl_reg;
    logic signed [ANG_W-1:0] out_reg;

    // Divider hookup
    logic [CFG_W-1:0] cnt_eff;
    logic [DVS_W-1:0] den;
    logic [DVD_W-1:0] conv_dvd;
    logic [SUM_W-1:0] sum_mag;
    logic [DVD_W-1:0] avg_dvd;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic [Q_W-1:0]   div_q;
    logic             div_ovf;
    logic             div_done;

    assign cnt_eff  = (cpt_reg == '0) ? CFG_W'(1) : cpt_reg;
    assign den      = {cnt_eff, 4'b0000};
    assign conv_dvd = {1'b0, prod_reg} + DVD_W'(den >> 1);
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign avg_dvd  = DVD_W'(sum_mag) + DVD_W'(seen_reg >> 1);
    assign div_dvd  = cmd.div_avg ? avg_dvd : conv_dvd;
    assign div_dvs  = cmd.div_avg ? DVS_W'(seen_reg) : den;

    jaf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .ovf      (div_ovf),
        .done     (div_done)
    );

    // Converted angle, saturated to the positive Q3.12 limit
    logic [ANG_W-1:0] angle;
    assign angle = (div_ovf || div_q[Q_W-1]) ? {1'b0, {(ANG_W-1){1'b1}}} : ANG_W'(div_q);

    // Window store
    logic             ram_re;
    logic [ANG_W-1:0] ram_rdata;

    assign ram_re = cmd.sum && (rd_idx_reg < seen_reg);

    jaf_ram #(
        .WIDTH (ANG_W),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (cmd.store),
        .waddr (wr_ptr_reg),
        .wdata (angle),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Average sign, offset and single wrap
    logic signed [ANG_W:0] avg;
    logic signed [V_W-1:0] v_sum;
    logic signed [V_W-1:0] v_wrap;

    always_comb begin
        avg   = sum_reg[SUM_W-1] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        v_sum = V_W'(avg) + V_W'(offset_reg);
        if (v_sum > PI_Q12) begin
            v_wrap = v_sum - TAU_Q12;
        end else if (v_sum < -PI_Q12) begin
            v_wrap = v_sum + TAU_Q12;
        end else begin
            v_wrap = v_sum;
        end
    end

    // Round to nearest, ties toward +inf, on the Q12 drop, then saturate
    logic signed [SCL_W:0]   rnd;
    logic signed [SCL_W:0]   shr;
    logic signed [ANG_W-1:0] sat;

    always_comb begin
        rnd = (SCL_W+1)'(scl_reg) + (SCL_W+1)'(2048);
        shr = rnd >>> 12;
        if (shr > (SCL_W+1)'(32767)) begin
            sat = {1'b0, {(ANG_W-1){1'b1}}};
        end else if (shr < -(SCL_W+1)'(32768)) begin
            sat = {1'b1, {(ANG_W-1){1'b0}}};
        end else begin
            sat = shr[ANG_W-1:0];
        end
    end

    // Control counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            seen_reg   <= '0;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= ram_re;
            if (cmd.store) begin
                wr_ptr_reg <= (wr_ptr_reg == WIN_LAST) ? '0 : wr_ptr_reg + 1'b1;
                if (seen_reg < WIN_CNT) begin
                    seen_reg <= seen_reg + 1'b1;
                end
                rd_idx_reg <= '0;
            end else if (ram_re) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    // Payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pos_reg <= s_raw_position;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(pos_reg) * PROD_W'(TAU_Q16);
        end
        if (cmd.store) begin
            sum_reg <= '0;
        end else if (rd_vld_reg) begin
            sum_reg <= sum_reg + SUM_W'($signed(ram_rdata));
        end
        if (cmd.wrap) begin
            v_reg <= v_wrap;
        end
        if (cmd.scale) begin
            scl_reg <= SCL_W'(v_reg) * SCL_W'(ratio_reg);
        end
        if (cmd.out_load) begin
            out_reg <= sat;
        end
    end

    assign stat.div_done  = div_done;
    assign stat.sum_done  = (rd_idx_reg == seen_reg) && !rd_vld_reg;
    assign m_joint_angle  = out_reg;

endmodule

>>> rtl/jaf_ctrl.sv
module jaf_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  jaf_pkg::stat_t stat,
    output jaf_pkg::cmd_t  cmd
);
    import jaf_pkg::*;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;

    // Sequence one beat through the datapath
    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_CDIV;
            end
            ST_CDIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_CWAIT;
            end
            ST_CWAIT: begin
                if (stat.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum = 1'b1;
                if (stat.sum_done) begin
                    state_next = ST_ADIV;
                end
            end
            ST_ADIV: begin
                cmd.div_start = 1'b1;
                cmd.div_avg   = 1'b1;
                state_next    = ST_AWAIT;
            end
            ST_AWAIT: begin
                if (stat.div_done) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free
                if (!mv_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

endmodule

>>> rtl/joint_angle_filter_core.sv
// Each input beat passes load, multiply, conversion divide, store, window sum, average divide,
// wrap, scale and output; a new beat is taken only once the previous one has left that sequence,
// whose length is set mostly by the two 16-step passes of the shared restoring divider.
// A new beat is taken while the previous result still waits in the output register.
// Reset (aresetn, synchronous, active low) clears the sequencer, counters and
// configuration; window contents stay undefined until written.
module joint_angle_filter_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [jaf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jaf_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jaf_pkg::POS_W-1:0]     s_raw_position,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [jaf_pkg::ANG_W-1:0] m_joint_angle
);
    import jaf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    jaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    jaf_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_raw_position (s_raw_position),
        .cmd            (cmd),
        .stat           (stat),
        .m_joint_angle  (m_joint_angle)
    );

endmodule

>>> rtl/jaf_checker.sv
module jaf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [jaf_pkg::ANG_W-1:0] m_joint_angle
);
    import jaf_pkg::*;

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pend_reg;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    // Track beats taken but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else if (in_beat && !out_beat) begin
            pend_reg <= pend_reg + 1'b1;
        end else if (out_beat && !in_beat) begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_joint_angle)))
        else $error("result beat dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_ready)
        else $error("input taken again before the current beat is processed");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_beat |-> (pend_reg != 2'd0))
        else $error("result beat with no input beat outstanding");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd3))
        else $error("more beats in flight than the design can hold");

endmodule

bind joint_angle_filter_core jaf_checker u_jaf_checker (.*);
